// ===== src/kbdec_pkg.sv =====
`default_nettype none
package kbdec_pkg;

    localparam int NUM_ROWS     = 8;
    localparam int KEYS_PER_ROW = 5;
    localparam int NUM_JOY      = 6;
    localparam int NUM_KEYS     = NUM_ROWS * KEYS_PER_ROW;

    localparam int MAP_W  = 11;
    localparam int IDX_W  = 3;
    localparam int JOY_W  = 7;

    localparam logic [MAP_W-1:0] JOY_MAP_RESET = 11'd255;
    localparam logic [7:0]       MASK_OFF      = 8'hff;

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_JOY_UP       = 3'd0;
    localparam logic [IDX_W-1:0] REG_JOY_DOWN     = 3'd1;
    localparam logic [IDX_W-1:0] REG_JOY_LEFT     = 3'd2;
    localparam logic [IDX_W-1:0] REG_JOY_RIGHT    = 3'd3;
    localparam logic [IDX_W-1:0] REG_JOY_FIRE     = 3'd4;
    localparam logic [IDX_W-1:0] REG_JOY_FIRE_TWO = 3'd5;

    // joystick bit tested by each map register, in register order
    localparam logic [2:0] JOY_BIT_POS [NUM_JOY] = '{3'd0, 3'd1, 3'd2, 3'd3, 3'd5, 3'd4};

    // caps shift and symbol shift key positions
    localparam logic [2:0] CAPS_ROW = 3'd0;
    localparam logic [2:0] CAPS_BIT = 3'd0;
    localparam logic [2:0] SYM_ROW  = 3'd7;
    localparam logic [2:0] SYM_BIT  = 3'd1;

    typedef logic [7:0]         byte_t;
    typedef logic [7:0][7:0]    rows_t;
    typedef logic [MAP_W-1:0]   joy_map_t;
    typedef joy_map_t [NUM_JOY-1:0] joy_maps_t;

    localparam byte_t TAB_PLAIN [NUM_KEYS] = '{
        8'h00, "z", "x", "c", "v",   "a", "s", "d", "f", "g",
        "q", "w", "e", "r", "t",     "1", "2", "3", "4", "5",
        "0", "9", "8", "7", "6",     "p", "o", "i", "u", "y",
        8'd10, "l", "k", "j", "h",   " ", 8'h00, "m", "n", "b"
    };

    localparam byte_t TAB_CAPS [NUM_KEYS] = '{
        8'h00, "Z", "X", "C", "V",   "A", "S", "D", "F", "G",
        "Q", "W", "E", "R", "T",     8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'd8, 8'h00, 8'h00, 8'h00, 8'h00, "P", "O", "I", "U", "Y",
        8'h00, "L", "K", "J", "H",   8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    localparam byte_t TAB_SYM [NUM_KEYS] = '{
        8'h00, ":", 8'h60, "?", "/", "~", "|", 8'h5c, "{", "}",
        8'h00, 8'h00, 8'h00, "<", ">", "!", "@", "#", "$", "%",
        "_", ")", "(", 8'h27, "&",   8'h22, ";", 8'h00, "[", "]",
        8'h00, "=", "+", "-", "^",   8'h00, 8'h00, ".", ",", "*"
    };

    function automatic logic [4:0] rev5(input logic [4:0] v);
        rev5 = {v[0], v[1], v[2], v[3], v[4]};
    endfunction

endpackage
`default_nettype wire

// ===== src/keyboard_scan_to_char_decoder_top.sv =====
// keyboard scan to character decoder
//
// input channel (s_valid/s_ready): one six-byte keyboard scan per request.
// the scan is remapped into eight active-low half-row bytes, the joystick
// overlay masks from the cfg registers are applied, and at most one ascii
// code is decoded. a decoded key blocks further codes until it reads released.
// result channel (m_valid/m_ready): eight rows, joystick bits and char_code
// (0 when no character this scan).
// a request passes from the input register to the result register on m_*.
// throughput: one request per cycle while the receiver does not stall; input
// register, one pass of remap and priority decode logic, result register.
// when the receiver stalls the result register holds and the input register
// still takes one more request; s_ready drops once both are full.
// reset (aresetn low, synchronous) empties both registers, clears the
// release wait and sets every joystick map to 255 (disabled).
// cfg_we writes cfg_wdata into register cfg_index at once; indexes past
// the last map are ignored. write only while the block is idle.
`default_nettype none
module keyboard_scan_to_char_decoder_top
    import kbdec_pkg::*;
(
    input  wire              aclk,
    input  wire              aresetn,

    input  wire              cfg_we,
    input  wire [IDX_W-1:0]  cfg_index,
    input  wire [MAP_W-1:0]  cfg_wdata,

    input  wire              s_valid,
    output logic             s_ready,
    input  wire  [7:0]       s_scan_byte_one,
    input  wire  [7:0]       s_scan_byte_two,
    input  wire  [7:0]       s_scan_byte_three,
    input  wire  [7:0]       s_scan_byte_four,
    input  wire  [7:0]       s_scan_byte_five,
    input  wire  [7:0]       s_scan_byte_six,

    output logic             m_valid,
    input  wire              m_ready,
    output logic [7:0]       m_row_zero,
    output logic [7:0]       m_row_one,
    output logic [7:0]       m_row_two,
    output logic [7:0]       m_row_three,
    output logic [7:0]       m_row_four,
    output logic [7:0]       m_row_five,
    output logic [7:0]       m_row_six,
    output logic [7:0]       m_row_seven,
    output logic [JOY_W-1:0] m_joystick_bits,
    output logic [7:0]       m_char_code
);

    joy_maps_t map_reg;

    logic  in_valid_reg;
    byte_t b1_reg, b2_reg, b3_reg, b4_reg, b5_reg, b6_reg;

    logic             out_valid_reg;
    rows_t            rows_out_reg;
    logic [JOY_W-1:0] joy_out_reg;
    byte_t            code_out_reg;

    rows_t            rows;
    logic [JOY_W-1:0] joy;
    byte_t            code;
    logic             advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NUM_JOY; k++) begin
                map_reg[k] <= JOY_MAP_RESET;
            end
        end else if (cfg_we) begin
            case (cfg_index)
                REG_JOY_UP:       map_reg[0] <= cfg_wdata;
                REG_JOY_DOWN:     map_reg[1] <= cfg_wdata;
                REG_JOY_LEFT:     map_reg[2] <= cfg_wdata;
                REG_JOY_RIGHT:    map_reg[3] <= cfg_wdata;
                REG_JOY_FIRE:     map_reg[4] <= cfg_wdata;
                REG_JOY_FIRE_TWO: map_reg[5] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            b1_reg <= s_scan_byte_one;
            b2_reg <= s_scan_byte_two;
            b3_reg <= s_scan_byte_three;
            b4_reg <= s_scan_byte_four;
            b5_reg <= s_scan_byte_five;
            b6_reg <= s_scan_byte_six;
        end
    end

    kbdec_remap u_remap (
        .b1   (b1_reg),
        .b2   (b2_reg),
        .b3   (b3_reg),
        .b4   (b4_reg),
        .b5   (b5_reg),
        .b6   (b6_reg),
        .maps (map_reg),
        .rows (rows),
        .joy  (joy)
    );

    kbdec_decode u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (advance),
        .rows      (rows),
        .char_code (code)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            rows_out_reg <= rows;
            joy_out_reg  <= joy;
            code_out_reg <= code;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_row_zero      = rows_out_reg[0];
    assign m_row_one       = rows_out_reg[1];
    assign m_row_two       = rows_out_reg[2];
    assign m_row_three     = rows_out_reg[3];
    assign m_row_four      = rows_out_reg[4];
    assign m_row_five      = rows_out_reg[5];
    assign m_row_six       = rows_out_reg[6];
    assign m_row_seven     = rows_out_reg[7];
    assign m_joystick_bits = joy_out_reg;
    assign m_char_code     = code_out_reg;

endmodule
`default_nettype wire

// ===== src/kbdec_remap.sv =====
`default_nettype none
module kbdec_remap
    import kbdec_pkg::*;
(
    input  wire  byte_t     b1,
    input  wire  byte_t     b2,
    input  wire  byte_t     b3,
    input  wire  byte_t     b4,
    input  wire  byte_t     b5,
    input  wire  byte_t     b6,
    input  wire  joy_maps_t maps,
    output rows_t           rows,
    output logic [JOY_W-1:0] joy
);

    rows_t base;

    always_comb begin
        base[0] = ~{3'b000, rev5(b1[6:2])};
        base[1] = ~{3'b000, rev5(b2[4:0])};
        base[2] = ~{3'b000, rev5({b3[2:0], b4[7:6]})};
        base[3] = ~{3'b000, rev5({b4[0], b5[7:4]})};
        base[4] = ~{3'b000, b5[3:0], b6[7]};
        base[5] = ~{3'b000, b4[5:1]};
        base[6] = ~{3'b000, b3[7:3]};
        base[7] = ~{3'b000, b1[1:0], b2[7:5]};
    end

    assign joy = b6[JOY_W-1:0];

    // joystick overlay: AND order does not matter
    always_comb begin
        rows = base;
        for (int k = 0; k < NUM_JOY; k++) begin
            if (joy[JOY_BIT_POS[k]] && (maps[k][7:0] != MASK_OFF)) begin
                rows[maps[k][10:8]] = rows[maps[k][10:8]] & maps[k][7:0];
            end
        end
    end

endmodule
`default_nettype wire

// ===== src/kbdec_decode.sv =====
`default_nettype none
module kbdec_decode
    import kbdec_pkg::*;
(
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        en,
    input  wire rows_t rows,
    output byte_t      char_code
);

    logic       await_reg, await_next;
    logic [2:0] held_row_reg, held_row_next;
    logic [2:0] held_bit_reg, held_bit_next;

    logic       still_held;
    logic       caps, sym;
    rows_t      work;
    logic       found;
    logic [2:0] sel_row, sel_bit;
    byte_t      sel_code;
    byte_t      entry;

    assign still_held = await_reg && !rows[held_row_reg][held_bit_reg];
    assign caps = !rows[CAPS_ROW][CAPS_BIT];
    assign sym  = !caps && !rows[SYM_ROW][SYM_BIT];

    // first pressed key with a table entry, lowest row and bit first
    always_comb begin
        work = rows;
        if (caps) begin
            work[CAPS_ROW] = MASK_OFF;
        end else if (sym) begin
            work[SYM_ROW] = MASK_OFF;
        end
        found    = 1'b0;
        sel_row  = 3'd0;
        sel_bit  = 3'd0;
        sel_code = 8'h00;
        entry    = 8'h00;
        for (int r = NUM_ROWS - 1; r >= 0; r--) begin
            for (int k = KEYS_PER_ROW - 1; k >= 0; k--) begin
                if (caps) begin
                    entry = TAB_CAPS[r * KEYS_PER_ROW + k];
                end else if (sym) begin
                    entry = TAB_SYM[r * KEYS_PER_ROW + k];
                end else begin
                    entry = TAB_PLAIN[r * KEYS_PER_ROW + k];
                end
                if (!work[r][k] && (entry != 8'h00)) begin
                    found    = 1'b1;
                    sel_row  = 3'(r);
                    sel_bit  = 3'(k);
                    sel_code = entry;
                end
            end
        end
    end

    always_comb begin
        await_next    = await_reg;
        held_row_next = held_row_reg;
        held_bit_next = held_bit_reg;
        char_code     = 8'h00;
        if (!still_held) begin
            await_next = found;
            if (found) begin
                held_row_next = sel_row;
                held_bit_next = sel_bit;
                char_code     = sel_code;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            await_reg    <= 1'b0;
            held_row_reg <= 3'd0;
            held_bit_reg <= 3'd0;
        end else if (en) begin
            await_reg    <= await_next;
            held_row_reg <= held_row_next;
            held_bit_reg <= held_bit_next;
        end
    end

    a_hit_sets_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        (en && char_code != 8'h00) |=> await_reg)
        else $error("key hit did not arm release wait");

    a_no_code_while_held: assert property (@(posedge aclk) disable iff (!aresetn)
        still_held |-> (char_code == 8'h00))
        else $error("character produced while key still held");

    a_held_bit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        await_reg |-> (held_bit_reg < 3'd5))
        else $error("held key bit out of range");

    a_hit_records_key: assert property (@(posedge aclk) disable iff (!aresetn)
        (en && char_code != 8'h00) |=>
            (held_row_reg == $past(sel_row) && held_bit_reg == $past(sel_bit)))
        else $error("held key position not recorded");

endmodule
`default_nettype wire
